/* sv/tsbq_pkg.sv */
// ----------------------------------------------------------------------------
// Three-section biquad filter: shared package
// Widths, codes, register map and state encoding used across the block.
// ----------------------------------------------------------------------------
package tsbq_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int NODE_WIDTH_DEF   = 24;
	localparam int COEF_WIDTH       = 18;
	localparam int GAIN_WIDTH       = 17;
	localparam int FRAC_BITS        = 16;
	localparam int CFG_ADDR_WIDTH   = 5;
	localparam int CFG_DATA_WIDTH   = 32;
	localparam int REG_IDX_WIDTH    = CFG_ADDR_WIDTH - 2;

	typedef enum logic [1:0] {
		OP_LOWPASS  = 2'd0,
		OP_HIGHPASS = 2'd1,
		OP_BANDPASS = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_FEEDBACK_FIRST  = 3'd0,
		REG_FEEDBACK_SECOND = 3'd1,
		REG_LOWPASS_GAIN    = 3'd2,
		REG_HIGHPASS_GAIN   = 3'd3,
		REG_BANDPASS_GAIN   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] feedback_first;
		logic signed [COEF_WIDTH-1:0] feedback_second;
		logic        [GAIN_WIDTH-1:0] lowpass_gain;
		logic        [GAIN_WIDTH-1:0] highpass_gain;
		logic        [GAIN_WIDTH-1:0] bandpass_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEEDBACK,
		ST_NODE,
		ST_GAIN,
		ST_FINISH
	} state_t;

endpackage

/* sv/tsbq_cfg.sv */
// ----------------------------------------------------------------------------
// Three-section biquad filter: configuration registers
// APB-style register file holding the feedback coefficients and gains.
// ----------------------------------------------------------------------------
module tsbq_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsbq_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [tsbq_pkg::CFG_DATA_WIDTH-1:0] pwdata,
	output logic [tsbq_pkg::CFG_DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	output tsbq_pkg::cfg_t                      cfg
);

	tsbq_pkg::cfg_t     cfg_q;
	tsbq_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = tsbq_pkg::reg_idx_t'(paddr[tsbq_pkg::CFG_ADDR_WIDTH-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				tsbq_pkg::REG_FEEDBACK_FIRST: begin
					cfg_q.feedback_first <= pwdata[tsbq_pkg::COEF_WIDTH-1:0];
				end
				tsbq_pkg::REG_FEEDBACK_SECOND: begin
					cfg_q.feedback_second <= pwdata[tsbq_pkg::COEF_WIDTH-1:0];
				end
				tsbq_pkg::REG_LOWPASS_GAIN: begin
					cfg_q.lowpass_gain <= pwdata[tsbq_pkg::GAIN_WIDTH-1:0];
				end
				tsbq_pkg::REG_HIGHPASS_GAIN: begin
					cfg_q.highpass_gain <= pwdata[tsbq_pkg::GAIN_WIDTH-1:0];
				end
				tsbq_pkg::REG_BANDPASS_GAIN: begin
					cfg_q.bandpass_gain <= pwdata[tsbq_pkg::GAIN_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			tsbq_pkg::REG_FEEDBACK_FIRST:  prdata = tsbq_pkg::CFG_DATA_WIDTH'(cfg_q.feedback_first);
			tsbq_pkg::REG_FEEDBACK_SECOND: prdata = tsbq_pkg::CFG_DATA_WIDTH'(cfg_q.feedback_second);
			tsbq_pkg::REG_LOWPASS_GAIN:    prdata = tsbq_pkg::CFG_DATA_WIDTH'(cfg_q.lowpass_gain);
			tsbq_pkg::REG_HIGHPASS_GAIN:   prdata = tsbq_pkg::CFG_DATA_WIDTH'(cfg_q.highpass_gain);
			tsbq_pkg::REG_BANDPASS_GAIN:   prdata = tsbq_pkg::CFG_DATA_WIDTH'(cfg_q.bandpass_gain);
			default:                       prdata = '0;
		endcase
	end

endmodule

/* sv/tsbq_mac.sv */
// ----------------------------------------------------------------------------
// Three-section biquad filter: serial-parallel multiply-accumulate
// Forms ca*A + cb*B one coefficient bit per cycle, LSB first, the top
// coefficient bit carrying negative weight.
// ----------------------------------------------------------------------------
module tsbq_mac #(
	parameter int MULT_WIDTH = tsbq_pkg::NODE_WIDTH_DEF + 2,
	parameter int COEF_WIDTH = tsbq_pkg::COEF_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic signed [COEF_WIDTH-1:0]                coef_a,
	input  logic signed [COEF_WIDTH-1:0]                coef_b,
	input  logic signed [MULT_WIDTH-1:0]                mult_a,
	input  logic signed [MULT_WIDTH-1:0]                mult_b,
	output logic                                        done,
	output logic signed [MULT_WIDTH+COEF_WIDTH+1:0]     prod
);

	localparam int AW   = MULT_WIDTH + 2;
	localparam int CNTW = (COEF_WIDTH > 1) ? $clog2(COEF_WIDTH) : 1;

	logic [COEF_WIDTH-1:0] ca_q;
	logic [COEF_WIDTH-1:0] cb_q;
	logic signed [AW-1:0]  hi_q;
	logic [COEF_WIDTH-1:0] lo_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  last;
	logic signed [AW-1:0]  pp;
	logic signed [AW-1:0]  sum;

	assign last = (cnt_q == CNTW'(COEF_WIDTH - 1));
	assign pp   = (ca_q[0] ? AW'(mult_a) : AW'(0)) + (cb_q[0] ? AW'(mult_b) : AW'(0));
	assign sum  = last ? (hi_q - pp) : (hi_q + pp);
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ca_q <= coef_a;
			cb_q <= coef_b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			ca_q <= ca_q >> 1;
			cb_q <= cb_q >> 1;
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[COEF_WIDTH-1:1]};
		end
	end

endmodule

/* sv/three_section_biquad_filter.sv */
// ----------------------------------------------------------------------------
// Three-section biquad filter
// Direct form II lowpass, highpass and bandpass sections sharing two feedback
// coefficients, each section with its own two-entry delay line.
// ----------------------------------------------------------------------------
// One serial-parallel multiplier takes one coefficient bit per cycle and does
// all the multiplications. An item with a valid section code is accepted, then
// the feedback product is formed, the node saturated and the delay line updated,
// the gain product formed and the output register loaded once it is free. An
// item with the unused section code goes straight from acceptance to the output
// register and gives a zero result. The next item is accepted while a finished
// result still waits in the output register.
// ----------------------------------------------------------------------------
module three_section_biquad_filter #(
	parameter int SAMPLE_WIDTH = tsbq_pkg::SAMPLE_WIDTH_DEF,
	parameter int NODE_WIDTH   = tsbq_pkg::NODE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsbq_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [tsbq_pkg::CFG_DATA_WIDTH-1:0] pwdata,
	output logic [tsbq_pkg::CFG_DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: sample_in.
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: sample_out.
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
	// Fields from bit 0: clipped.
	output logic                                m_tuser
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int NW   = NODE_WIDTH;
	localparam int DW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int CW   = tsbq_pkg::COEF_WIDTH;
	localparam int FB   = tsbq_pkg::FRAC_BITS;
	localparam int MW   = NW + 2;
	localparam int PW   = MW + CW + 2;
	localparam int RW   = PW - FB;

	localparam logic signed [RW:0]   NODE_MAX = {{(RW + 2 - NW){1'b0}}, {(NW - 1){1'b1}}};
	localparam logic signed [RW:0]   NODE_MIN = ~NODE_MAX;
	localparam logic signed [RW-1:0] OUT_MAX  = {{(RW + 1 - SW){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic signed [RW-1:0] OUT_MIN  = ~OUT_MAX;

	tsbq_pkg::cfg_t   cfg;
	tsbq_pkg::state_t state_q;
	tsbq_pkg::state_t state_nxt;
	tsbq_pkg::op_t    op_in;
	tsbq_pkg::op_t    op_q;

	logic signed [SW-1:0]    x_q;
	logic signed [NW-1:0]    d1_q [3];
	logic signed [NW-1:0]    d2_q [3];
	logic signed [MW-1:0]    taps_q;
	logic                    clip_q;
	logic                    m_tvalid_q;
	logic [SW-1:0]           y_q;
	logic                    clip_out_q;

	logic                    mac_start;
	logic                    mac_done;
	logic signed [CW-1:0]    coef_a;
	logic signed [CW-1:0]    coef_b;
	logic signed [MW-1:0]    mult_a;
	logic signed [MW-1:0]    mult_b;
	logic signed [PW-1:0]    prod;

	logic                    delay_we;
	logic                    out_free;
	logic                    out_load;

	logic signed [NW-1:0]    d1_sel;
	logic signed [NW-1:0]    d2_sel;
	logic [tsbq_pkg::GAIN_WIDTH-1:0] gain_sel;
	logic signed [RW-1:0]    prod_rnd;
	logic signed [RW:0]      node_full;
	logic signed [NW-1:0]    node_sat;
	logic                    node_clip;
	logic signed [MW-1:0]    node_ext;
	logic signed [MW-1:0]    d1_ext;
	logic signed [MW-1:0]    d2_ext;
	logic signed [MW-1:0]    taps;
	logic [SW-1:0]           y_nxt;
	logic                    clip_nxt;

	tsbq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsbq_mac #(
		.MULT_WIDTH (MW),
		.COEF_WIDTH (CW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.coef_a (coef_a),
		.coef_b (coef_b),
		.mult_a (mult_a),
		.mult_b (mult_b),
		.done   (mac_done),
		.prod   (prod)
	);

	assign op_in    = tsbq_pkg::op_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tsbq_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = (op_in == tsbq_pkg::OP_NONE) ? tsbq_pkg::ST_FINISH
						: tsbq_pkg::ST_FEEDBACK;
				end
			end
			tsbq_pkg::ST_FEEDBACK: begin
				if (mac_done) begin
					state_nxt = tsbq_pkg::ST_NODE;
				end
			end
			tsbq_pkg::ST_NODE: begin
				state_nxt = tsbq_pkg::ST_GAIN;
			end
			tsbq_pkg::ST_GAIN: begin
				if (mac_done) begin
					state_nxt = tsbq_pkg::ST_FINISH;
				end
			end
			tsbq_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = tsbq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tsbq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mac_start = 1'b0;
		delay_we  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tsbq_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				mac_start = s_tvalid && (op_in != tsbq_pkg::OP_NONE);
			end
			tsbq_pkg::ST_NODE: begin
				mac_start = 1'b1;
				delay_we  = 1'b1;
			end
			tsbq_pkg::ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsbq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		case (op_q)
			tsbq_pkg::OP_LOWPASS: begin
				d1_sel   = d1_q[0];
				d2_sel   = d2_q[0];
				gain_sel = cfg.lowpass_gain;
			end
			tsbq_pkg::OP_HIGHPASS: begin
				d1_sel   = d1_q[1];
				d2_sel   = d2_q[1];
				gain_sel = cfg.highpass_gain;
			end
			tsbq_pkg::OP_BANDPASS: begin
				d1_sel   = d1_q[2];
				d2_sel   = d2_q[2];
				gain_sel = cfg.bandpass_gain;
			end
			default: begin
				d1_sel   = '0;
				d2_sel   = '0;
				gain_sel = '0;
			end
		endcase
	end

	assign d1_ext = {{2{d1_sel[NW-1]}}, d1_sel};
	assign d2_ext = {{2{d2_sel[NW-1]}}, d2_sel};

	assign coef_a = (state_q == tsbq_pkg::ST_IDLE) ? cfg.feedback_first : CW'(gain_sel);
	assign coef_b = (state_q == tsbq_pkg::ST_IDLE) ? cfg.feedback_second : CW'(0);
	assign mult_a = (state_q == tsbq_pkg::ST_GAIN) ? taps_q : d1_ext;
	assign mult_b = (state_q == tsbq_pkg::ST_GAIN) ? MW'(0) : d2_ext;

	assign prod_rnd  = prod[PW-1:FB] + RW'(prod[FB-1]);
	assign node_full = {{(RW + 1 - SW){x_q[SW-1]}}, x_q} - (RW + 1)'(prod_rnd);

	always_comb begin
		node_clip = 1'b0;
		if (node_full > NODE_MAX) begin
			node_sat  = NODE_MAX[NW-1:0];
			node_clip = 1'b1;
		end else if (node_full < NODE_MIN) begin
			node_sat  = NODE_MIN[NW-1:0];
			node_clip = 1'b1;
		end else begin
			node_sat = node_full[NW-1:0];
		end
	end

	assign node_ext = {{2{node_sat[NW-1]}}, node_sat};

	always_comb begin
		case (op_q)
			tsbq_pkg::OP_LOWPASS:  taps = node_ext + (d1_ext <<< 1) + d2_ext;
			tsbq_pkg::OP_HIGHPASS: taps = node_ext - (d1_ext <<< 1) + d2_ext;
			tsbq_pkg::OP_BANDPASS: taps = node_ext - d2_ext;
			default:               taps = '0;
		endcase
	end

	always_comb begin
		clip_nxt = clip_q;
		if (op_q == tsbq_pkg::OP_NONE) begin
			y_nxt    = '0;
			clip_nxt = 1'b0;
		end else if (prod_rnd > OUT_MAX) begin
			y_nxt    = OUT_MAX[SW-1:0];
			clip_nxt = 1'b1;
		end else if (prod_rnd < OUT_MIN) begin
			y_nxt    = OUT_MIN[SW-1:0];
			clip_nxt = 1'b1;
		end else begin
			y_nxt = prod_rnd[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= op_in;
			x_q    <= s_tdata[SW-1:0];
			clip_q <= 1'b0;
		end else if (delay_we) begin
			clip_q <= node_clip;
		end
		if (delay_we) begin
			taps_q <= taps;
		end
		if (out_load) begin
			y_q        <= y_nxt;
			clip_out_q <= clip_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else if (delay_we) begin
			for (int i = 0; i < 3; i++) begin
				if (op_q == tsbq_pkg::op_t'(2'(i))) begin
					d2_q[i] <= d1_q[i];
					d1_q[i] <= node_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'(y_q);
	assign m_tuser  = clip_out_q;

endmodule
